>>> design/finder_pattern_run_ratio_check_macros.svh
// Assertion helpers for the finder pattern run ratio check.
`ifndef FINDER_PATTERN_RUN_RATIO_CHECK_MACROS_SVH
`define FINDER_PATTERN_RUN_RATIO_CHECK_MACROS_SVH

// Property checked on clk_i, masked while rst_ni is low.
`define FPRC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fprc assertion failed");

// Same, with a caller-supplied message.
`define FPRC_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

>>> design/fprc_pkg.sv
package fprc_pkg;

  // Ratio register width and scale (one third of longest, in hundredths).
  localparam int unsigned RatioW     = 10;
  localparam int unsigned RatioScale = 300;
  localparam int unsigned MinRuns    = 5;

  // Config register indexes.
  localparam int unsigned  CfgAddrW = 1;
  localparam logic [0:0]   RegLow   = 1'b0;
  localparam logic [0:0]   RegHigh  = 1'b1;

  localparam logic [RatioW-1:0] LowReset  = 10'd40;
  localparam logic [RatioW-1:0] HighReset = 10'd225;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFew   = 2'd1,
    StEdge  = 2'd2,
    StRatio = 2'd3
  } fprc_status_e;

  // Structural verdict flags of a finished row.
  typedef struct packed {
    logic few_runs;
    logic at_edge;
  } fprc_flags_t;

endpackage

>>> design/finder_pattern_run_ratio_check.sv
// Finder pattern 1:1:3:1:1 run ratio check on one scan row. Pixels stream in
// one per clock (tdata = pixel byte, tlast marks the last pixel of the row);
// a nonzero byte is white, zero is black. The row is run-length coded on the
// fly and the first longest run is tracked with two runs on each side. Each
// row end yields exactly one verdict on the master side: tdata[0] is
// pattern_ok, tdata[2:1] the status (0 ok, 1 fewer than five runs, 2 longest
// run at the edge, 3 a neighbour run outside the ratio window). A neighbour
// passes when 300*run lies strictly between low*longest and high*longest,
// the bounds being in hundredths of one third of the longest run. Run lengths
// and the run count saturate at MaxWidth. Throughput is one pixel per cycle,
// including back-to-back row ends, while the master side takes verdicts; a
// verdict passes the summary, product and result registers in order. These
// three registers buffer up to three verdicts, so a stalled master side holds
// the slave side only once all three are full. Ratio registers are written
// over the cfg port (index 0 low, 1 high) by the user only while the block is
// idle, which the block does not enforce; cfg_ready_o is always high.
module finder_pattern_run_ratio_check #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [7:0]                           s_axis_tdata_i,  // [7:0] pixel
  input  logic                                 s_axis_tlast_i,  // row_end
  // master side
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // [0] pattern_ok, [2:1] status
  // config write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fprc_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [fprc_pkg::RatioW-1:0]          cfg_data_i
);

  localparam int unsigned RunW = $clog2(MaxWidth + 1);

  logic [fprc_pkg::RatioW-1:0]  low_q, high_q;
  logic                         accept, snap_valid, snap_take;
  fprc_pkg::fprc_flags_t        snap_flags;
  logic [RunW-1:0]              snap_longest;
  logic [3:0][RunW-1:0]         snap_win;
  logic                         pattern_ok;
  fprc_pkg::fprc_status_e       status;

  // ratio registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= fprc_pkg::LowReset;
      high_q <= fprc_pkg::HighReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        fprc_pkg::RegLow:  low_q  <= cfg_data_i;
        fprc_pkg::RegHigh: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // run-length coding, longest-run window, row summary register
  fprc_run_tracker #(.MaxWidth(MaxWidth)) u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pixel_i        (s_axis_tdata_i),
    .row_end_i      (s_axis_tlast_i),
    .snap_take_i    (snap_take),
    .in_ready_o     (s_axis_tready_o),
    .snap_valid_o   (snap_valid),
    .snap_flags_o   (snap_flags),
    .snap_longest_o (snap_longest),
    .snap_win_o     (snap_win)
  );

  // cross-multiplied ratio test and result register
  fprc_ratio_check #(.MaxWidth(MaxWidth)) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .low_i          (low_q),
    .high_i         (high_q),
    .snap_valid_i   (snap_valid),
    .snap_flags_i   (snap_flags),
    .snap_longest_i (snap_longest),
    .snap_win_i     (snap_win),
    .snap_take_o    (snap_take),
    .res_ready_i    (m_axis_tready_i),
    .res_valid_o    (m_axis_tvalid_o),
    .pattern_ok_o   (pattern_ok),
    .status_o       (status)
  );

  assign m_axis_tdata_o = {5'b0, status, pattern_ok};

endmodule

>>> design/fprc_run_close.sv
// Closes one run: updates longest run, its window, the run count and the run history.
module fprc_run_close #(
  parameter int unsigned MaxWidth = 2048,
  localparam int unsigned RunW = $clog2(MaxWidth + 1)
) (
  input  logic [RunW-1:0]       seen_i,
  input  logic [1:0][RunW-1:0]  prev_i,
  input  logic [RunW-1:0]       longest_i,
  input  logic                  lead_i,
  input  logic [3:0][RunW-1:0]  win_i,
  input  logic [1:0]            fill_i,
  input  logic [RunW-1:0]       len_i,
  output logic [RunW-1:0]       seen_o,
  output logic [1:0][RunW-1:0]  prev_o,
  output logic [RunW-1:0]       longest_o,
  output logic                  lead_o,
  output logic [3:0][RunW-1:0]  win_o,
  output logic [1:0]            fill_o
);

  localparam logic [RunW-1:0] MaxRun = RunW'(MaxWidth);

  logic take_new;

  assign take_new = (seen_i == '0) || (len_i > longest_i);

  always_comb begin
    longest_o = longest_i;
    lead_o    = lead_i;
    win_o     = win_i;
    fill_o    = fill_i;
    if (take_new) begin
      longest_o = len_i;
      lead_o    = (seen_i >= RunW'(2));
      win_o[0]  = prev_i[0];
      win_o[1]  = prev_i[1];
      win_o[2]  = '0;
      win_o[3]  = '0;
      fill_o    = '0;
    end else if (fill_i < 2'd2) begin
      if (fill_i[0]) begin
        win_o[3] = len_i;
      end else begin
        win_o[2] = len_i;
      end
      fill_o = fill_i + 2'd1;
    end
    prev_o[0] = prev_i[1];
    prev_o[1] = len_i;
    seen_o    = (seen_i < MaxRun) ? seen_i + RunW'(1) : seen_i;
  end

endmodule

>>> design/fprc_run_tracker.sv
// Run-length coder for one row; snapshots the row summary at row end.
module fprc_run_tracker #(
  parameter int unsigned MaxWidth = 2048,
  localparam int unsigned RunW = $clog2(MaxWidth + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                pixel_i,
  input  logic                      row_end_i,
  input  logic                      snap_take_i,
  output logic                      in_ready_o,
  output logic                      snap_valid_o,
  output fprc_pkg::fprc_flags_t     snap_flags_o,
  output logic [RunW-1:0]           snap_longest_o,
  output logic [3:0][RunW-1:0]      snap_win_o
);

  localparam logic [RunW-1:0] MaxRun = RunW'(MaxWidth);

  logic                     last_q;
  logic [RunW-1:0]          cur_q, seen_q, longest_q;
  logic [1:0][RunW-1:0]     prev_q;
  logic                     lead_q;
  logic [3:0][RunW-1:0]     win_q;
  logic [1:0]               fill_q;
  logic                     snap_valid_q;

  logic                     colour, close_a;
  logic [RunW-1:0]          cur_d;

  // after first close (colour change)
  logic [RunW-1:0]          seen_a, longest_a, seen_s, longest_s;
  logic [1:0][RunW-1:0]     prev_a, prev_s;
  logic                     lead_a, lead_s;
  logic [3:0][RunW-1:0]     win_a, win_s;
  logic [1:0]               fill_a, fill_s;

  // after row-end close
  logic [RunW-1:0]          seen_b, longest_b;
  logic [1:0][RunW-1:0]     prev_b;
  logic                     lead_b;
  logic [3:0][RunW-1:0]     win_b;
  logic [1:0]               fill_b;

  assign colour  = |pixel_i;
  assign close_a = (cur_q != '0) && (colour != last_q);

  always_comb begin
    if (cur_q == '0 || close_a) begin
      cur_d = RunW'(1);
    end else if (cur_q < MaxRun) begin
      cur_d = cur_q + RunW'(1);
    end else begin
      cur_d = cur_q;
    end
  end

  fprc_run_close #(.MaxWidth(MaxWidth)) u_close_a (
    .seen_i(seen_q), .prev_i(prev_q), .longest_i(longest_q), .lead_i(lead_q),
    .win_i(win_q), .fill_i(fill_q), .len_i(cur_q),
    .seen_o(seen_a), .prev_o(prev_a), .longest_o(longest_a), .lead_o(lead_a),
    .win_o(win_a), .fill_o(fill_a)
  );

  assign seen_s    = close_a ? seen_a    : seen_q;
  assign prev_s    = close_a ? prev_a    : prev_q;
  assign longest_s = close_a ? longest_a : longest_q;
  assign lead_s    = close_a ? lead_a    : lead_q;
  assign win_s     = close_a ? win_a     : win_q;
  assign fill_s    = close_a ? fill_a    : fill_q;

  fprc_run_close #(.MaxWidth(MaxWidth)) u_close_b (
    .seen_i(seen_s), .prev_i(prev_s), .longest_i(longest_s), .lead_i(lead_s),
    .win_i(win_s), .fill_i(fill_s), .len_i(cur_d),
    .seen_o(seen_b), .prev_o(prev_b), .longest_o(longest_b), .lead_o(lead_b),
    .win_o(win_b), .fill_o(fill_b)
  );

  assign in_ready_o = !snap_valid_q || snap_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      cur_q     <= '0;
      seen_q    <= '0;
      prev_q    <= '0;
      longest_q <= '0;
      lead_q    <= 1'b0;
      win_q     <= '0;
      fill_q    <= '0;
    end else if (accept_i) begin
      if (row_end_i) begin
        last_q    <= 1'b0;
        cur_q     <= '0;
        seen_q    <= '0;
        prev_q    <= '0;
        longest_q <= '0;
        lead_q    <= 1'b0;
        win_q     <= '0;
        fill_q    <= '0;
      end else begin
        last_q    <= colour;
        cur_q     <= cur_d;
        seen_q    <= seen_s;
        prev_q    <= prev_s;
        longest_q <= longest_s;
        lead_q    <= lead_s;
        win_q     <= win_s;
        fill_q    <= fill_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (accept_i && row_end_i) begin
      snap_valid_q <= 1'b1;
    end else if (snap_take_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  // summary payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && row_end_i) begin
      snap_flags_o.few_runs <= (seen_b < RunW'(fprc_pkg::MinRuns));
      snap_flags_o.at_edge  <= !lead_b || (fill_b != 2'd2);
      snap_longest_o        <= longest_b;
      snap_win_o            <= win_b;
    end
  end

  assign snap_valid_o = snap_valid_q;

endmodule

>>> design/fprc_ratio_check.sv
// Two-stage verdict: products, then compares into the result register.
module fprc_ratio_check #(
  parameter int unsigned MaxWidth = 2048,
  localparam int unsigned RunW = $clog2(MaxWidth + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [fprc_pkg::RatioW-1:0]        low_i,
  input  logic [fprc_pkg::RatioW-1:0]        high_i,
  input  logic                               snap_valid_i,
  input  fprc_pkg::fprc_flags_t              snap_flags_i,
  input  logic [RunW-1:0]                    snap_longest_i,
  input  logic [3:0][RunW-1:0]               snap_win_i,
  output logic                               snap_take_o,
  input  logic                               res_ready_i,
  output logic                               res_valid_o,
  output logic                               pattern_ok_o,
  output fprc_pkg::fprc_status_e             status_o
);

  localparam int unsigned PW = fprc_pkg::RatioW + RunW;
  localparam logic [PW-1:0] Scale = PW'(fprc_pkg::RatioScale);

  logic                    v2_q, res_valid_q;
  fprc_pkg::fprc_flags_t   flags_q;
  logic [PW-1:0]           lo_q, hi_q;
  logic [3:0][PW-1:0]      sc_q;
  logic                    out_free, v2_free, ratio_bad;
  fprc_pkg::fprc_status_e  status_d;

  assign out_free    = !res_valid_q || res_ready_i;
  assign v2_free     = !v2_q || out_free;
  assign snap_take_o = snap_valid_i && v2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (v2_free) begin
        v2_q <= snap_valid_i;
      end
      if (out_free) begin
        res_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      flags_q <= snap_flags_i;
      lo_q    <= PW'(low_i) * PW'(snap_longest_i);
      hi_q    <= PW'(high_i) * PW'(snap_longest_i);
      for (int k = 0; k < 4; k++) begin
        sc_q[k] <= PW'(snap_win_i[k]) * Scale;
      end
    end
  end

  always_comb begin
    ratio_bad = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ratio_bad = ratio_bad || !((sc_q[k] > lo_q) && (sc_q[k] < hi_q));
    end
    if (flags_q.few_runs) begin
      status_d = fprc_pkg::StFew;
    end else if (flags_q.at_edge) begin
      status_d = fprc_pkg::StEdge;
    end else if (ratio_bad) begin
      status_d = fprc_pkg::StRatio;
    end else begin
      status_d = fprc_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && out_free) begin
      status_o     <= status_d;
      pattern_ok_o <= (status_d == fprc_pkg::StOk);
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

>>> design/fprc_checker.sv
`include "finder_pattern_run_ratio_check_macros.svh"

// Port-level checks for the finder pattern run ratio check.
module fprc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [7:0]                      s_axis_tdata_i,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [7:0]                      m_axis_tdata_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [fprc_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input logic [fprc_pkg::RatioW-1:0]     cfg_data_i
);

  // stalled verdict holds its value
  `FPRC_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))

  // pattern_ok agrees with status, padding stays zero
  `FPRC_ASSERT_MSG(a_ok_status, m_axis_tvalid_o |-> ((m_axis_tdata_o[0] == (m_axis_tdata_o[2:1] == fprc_pkg::StOk)) && (m_axis_tdata_o[7:3] == 5'b0)), "pattern_ok disagrees with status")

  // with the output empty the pipeline has room for a pixel
  `FPRC_ASSERT_MSG(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")

  // config port never stalls
  `FPRC_ASSERT(a_cfg_ready, cfg_ready_o)

endmodule

bind finder_pattern_run_ratio_check fprc_checker u_fprc_checker (.*);
